@@ design/pot_pkg.sv @@
package pot_pkg;

    localparam int PORTS = 1024;
    localparam int PORT_W = $clog2(PORTS);
    localparam int CNT_W = $clog2(PORTS + 1);
    localparam int ID_W = 16;
    localparam int OWNER_W = 2 * ID_W;
    localparam int ENTRY_W = OWNER_W + 1;

    localparam logic [1:0] FUNC_REGISTER = 2'd0;
    localparam logic [1:0] FUNC_UNREGISTER = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;
    localparam logic [1:0] FUNC_UNREG_ALL = 2'd3;

    localparam logic [2:0] STATUS_OK = 3'd0;
    localparam logic [2:0] STATUS_BAD_PORT = 3'd1;
    localparam logic [2:0] STATUS_ALREADY = 3'd2;
    localparam logic [2:0] STATUS_NOT_REG = 3'd3;
    localparam logic [2:0] STATUS_NOT_OWNER = 3'd4;

    typedef enum logic [2:0] {
        CMD_REGISTER,
        CMD_UNREGISTER,
        CMD_LOOKUP,
        CMD_UNREG_ALL,
        CMD_BAD_PORT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [PORT_W-1:0]     port;
        logic [OWNER_W-1:0]    caller;
    } cmd_t;

endpackage

@@ design/port_owner_table.sv @@
// Port owner table for 1024 ports, held in one RAM with a separate read and write port and
// a valid bit per entry. After reset the table is cleared one entry a cycle; up to two
// transactions are queued meanwhile and are answered once the clear is done. Register,
// unregister and lookup each read the RAM first, then do the write-back and load the result;
// a bad port number is answered without touching the RAM. Unregister-all walks the whole RAM,
// reading one entry and writing back the previous one each cycle. A two-deep command queue
// sits between the input and the table sequencer, and the result register lets the next
// transaction start while a result is still waiting to be taken.
module port_owner_table
    import pot_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [10:0]        s_port,
    input  logic [ID_W-1:0]    s_caller_proc,
    input  logic [ID_W-1:0]    s_caller_thread,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [ID_W-1:0]    m_owner_proc,
    output logic [ID_W-1:0]    m_owner_thread
);

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    pot_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_port          (s_port),
        .s_caller_proc   (s_caller_proc),
        .s_caller_thread (s_caller_thread),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .q_pop           (q_pop)
    );

    pot_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_owner_proc   (m_owner_proc),
        .m_owner_thread (m_owner_thread)
    );

endmodule

@@ design/pot_ram.sv @@
module pot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/pot_front.sv @@
module pot_front
    import pot_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [10:0]        s_port,
    input  logic [ID_W-1:0]    s_caller_proc,
    input  logic [ID_W-1:0]    s_caller_thread,
    output logic               q_valid,
    output cmd_t               q_cmd,
    input  logic               q_pop
);

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       cmd_in;
    logic       push;
    logic       bad_port;

    // Ports beyond the table are caught here so the back end never touches the RAM for them.
    assign bad_port = {1'b0, s_port} >= 12'(PORTS);

    always_comb begin
        cmd_in.port = s_port[PORT_W-1:0];
        cmd_in.caller = {s_caller_proc, s_caller_thread};
        unique case (s_func)
            FUNC_REGISTER:   cmd_in.kind = bad_port ? CMD_BAD_PORT : CMD_REGISTER;
            FUNC_UNREGISTER: cmd_in.kind = bad_port ? CMD_BAD_PORT : CMD_UNREGISTER;
            FUNC_LOOKUP:     cmd_in.kind = bad_port ? CMD_BAD_PORT : CMD_LOOKUP;
            FUNC_UNREG_ALL:  cmd_in.kind = CMD_UNREG_ALL;
            default:         cmd_in.kind = CMD_UNREG_ALL;
        endcase
    end

    assign s_ready = aresetn && (count_reg != 2'd2);
    assign push = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> count_reg != 2'd0)
        else $error("command queue popped while empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("command queue count out of range");
`endif

endmodule

@@ design/pot_back.sv @@
module pot_back
    import pot_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [ID_W-1:0]    m_owner_proc,
    output logic [ID_W-1:0]    m_owner_thread
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_prev;
    cmd_t                cmd_reg;
    logic                m_valid_reg;
    logic [2:0]          m_status_reg;
    logic [ID_W-1:0]     m_proc_reg;
    logic [ID_W-1:0]     m_thread_reg;

    logic                out_free;
    logic                out_load;
    logic                ram_we;
    logic [PORT_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [PORT_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                rd_valid;
    logic [OWNER_W-1:0]  rd_owner;
    logic                walk_hit;

    logic [2:0]          ex_status;
    logic                ex_we;
    logic [ENTRY_W-1:0]  ex_wdata;
    logic [ID_W-1:0]     ex_proc;
    logic [ID_W-1:0]     ex_thread;

    // Each entry holds a valid bit above the 32-bit owner id.
    pot_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(PORTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_valid = ram_rdata[ENTRY_W-1];
    assign rd_owner = ram_rdata[OWNER_W-1:0];
    assign out_free = !m_valid_reg || m_ready;
    assign cnt_prev = cnt_reg - CNT_W'(1);
    assign walk_hit = (cnt_reg != '0) && rd_valid && (rd_owner == cmd_reg.caller);

    assign q_pop = (state_reg == ST_IDLE) && q_valid
                   && (q_cmd.kind != CMD_BAD_PORT || out_free);

    // A new result is loaded into the output register in these cycles.
    assign out_load = (q_pop && q_cmd.kind == CMD_BAD_PORT)
                      || ((state_reg == ST_EXEC || state_reg == ST_DONE) && out_free);

    always_comb begin
        ex_status = STATUS_OK;
        ex_we = 1'b0;
        ex_wdata = {1'b0, rd_owner};
        ex_proc = '0;
        ex_thread = '0;
        case (cmd_reg.kind)
            CMD_REGISTER: begin
                if (rd_valid) begin
                    ex_status = STATUS_ALREADY;
                end else begin
                    ex_we = 1'b1;
                    ex_wdata = {1'b1, cmd_reg.caller};
                end
            end
            CMD_UNREGISTER: begin
                if (!rd_valid) begin
                    ex_status = STATUS_NOT_REG;
                end else if (rd_owner[OWNER_W-1:ID_W] != cmd_reg.caller[OWNER_W-1:ID_W]) begin
                    ex_status = STATUS_NOT_OWNER;
                end else begin
                    ex_we = 1'b1;
                end
            end
            CMD_LOOKUP: begin
                if (!rd_valid) begin
                    ex_status = STATUS_NOT_REG;
                end else begin
                    ex_proc = rd_owner[OWNER_W-1:ID_W];
                    ex_thread = rd_owner[ID_W-1:0];
                end
            end
            default: begin
                ex_status = STATUS_OK;
            end
        endcase
    end

    // The walk reads entry n while it writes back entry n-1, so the RAM sees distinct addresses.
    always_comb begin
        ram_we = 1'b0;
        ram_waddr = cmd_reg.port;
        ram_wdata = ex_wdata;
        ram_re = 1'b0;
        ram_raddr = q_cmd.port;
        case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = cnt_reg[PORT_W-1:0];
                ram_wdata = '0;
            end
            ST_IDLE: begin
                ram_re = q_pop && (q_cmd.kind == CMD_REGISTER || q_cmd.kind == CMD_UNREGISTER
                                   || q_cmd.kind == CMD_LOOKUP);
            end
            ST_EXEC: begin
                ram_we = out_free && ex_we;
            end
            ST_WALK: begin
                ram_we = walk_hit;
                ram_waddr = cnt_prev[PORT_W-1:0];
                ram_wdata = {1'b0, rd_owner};
                ram_re = (cnt_reg != CNT_W'(PORTS));
                ram_raddr = cnt_reg[PORT_W-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= out_load || (m_valid_reg && !m_ready);
            unique case (state_reg)
                ST_CLEAR: begin
                    if (cnt_reg == CNT_W'(PORTS - 1)) begin
                        cnt_reg <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (q_pop) begin
                        cmd_reg <= q_cmd;
                        case (q_cmd.kind)
                            CMD_BAD_PORT: begin
                                m_status_reg <= STATUS_BAD_PORT;
                                m_proc_reg <= '0;
                                m_thread_reg <= '0;
                            end
                            CMD_UNREG_ALL: begin
                                cnt_reg <= '0;
                                state_reg <= ST_WALK;
                            end
                            default: begin
                                state_reg <= ST_EXEC;
                            end
                        endcase
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        m_status_reg <= ex_status;
                        m_proc_reg <= ex_proc;
                        m_thread_reg <= ex_thread;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_WALK: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(PORTS)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_status_reg <= STATUS_OK;
                        m_proc_reg <= '0;
                        m_thread_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_owner_proc = m_proc_reg;
    assign m_owner_thread = m_thread_reg;

`ifndef NO_ASSERTIONS
    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !q_pop)
        else $error("command taken before the table was cleared");

    a_ram_no_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("RAM read and write at the same address");

    a_owner_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != STATUS_OK |-> m_proc_reg == '0 && m_thread_reg == '0)
        else $error("owner fields set on a failed transaction");

    a_walk_ends_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK && cnt_reg == CNT_W'(PORTS) |=> state_reg == ST_DONE)
        else $error("unregister-all walk did not finish");
`endif

endmodule

@@ verif/tb_port_owner_table.sv @@
module tb_port_owner_table;
    timeunit 1ns;
    timeprecision 1ps;
    import pot_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int LONG_HOLD = 300;
    localparam int HOT_PORTS = 12;
    localparam int CALLERS = 6;

    typedef struct {
        logic [2:0]      status;
        logic [ID_W-1:0] oproc;
        logic [ID_W-1:0] othread;
    } reply_t;

    // Mirrors the ownership table and holds the replies still owed by the block.
    class port_table_model;
        bit                 owned[PORTS];
        logic [OWNER_W-1:0] owner[PORTS];
        reply_t             pending[$];
        int                 errors;
        int                 func_seen[4];
        int                 status_seen[5];

        function void apply_request(logic [1:0] func, logic [10:0] port,
                                    logic [ID_W-1:0] cproc, logic [ID_W-1:0] cthread);
            reply_t             r;
            logic [OWNER_W-1:0] caller;
            caller = {cproc, cthread};
            r.status = STATUS_OK;
            r.oproc = '0;
            r.othread = '0;
            func_seen[func]++;
            if (func == FUNC_UNREG_ALL) begin
                // Only an exact match on process and thread releases a port here.
                for (int i = 0; i < PORTS; i++) begin
                    if (owned[i] && owner[i] == caller)
                        owned[i] = 1'b0;
                end
            end else if (port >= PORTS) begin
                r.status = STATUS_BAD_PORT;
            end else if (func == FUNC_REGISTER) begin
                if (owned[port]) begin
                    r.status = STATUS_ALREADY;
                end else begin
                    owned[port] = 1'b1;
                    owner[port] = caller;
                end
            end else if (!owned[port]) begin
                r.status = STATUS_NOT_REG;
            end else if (func == FUNC_UNREGISTER) begin
                // Any thread of the owning process may release the port.
                if (owner[port][OWNER_W-1:ID_W] != cproc)
                    r.status = STATUS_NOT_OWNER;
                else
                    owned[port] = 1'b0;
            end else begin
                r.oproc = owner[port][OWNER_W-1:ID_W];
                r.othread = owner[port][ID_W-1:0];
            end
            pending.push_back(r);
        endfunction

        function void compare_field(string what, logic [ID_W-1:0] exp, logic [ID_W-1:0] act);
            if (exp !== act) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp, act);
                errors++;
            end
        endfunction

        function void check_reply(logic [2:0] status, logic [ID_W-1:0] oproc,
                                  logic [ID_W-1:0] othread);
            reply_t e;
            if (pending.size() == 0) begin
                $display("%0t ns: unexpected reply, expected none, actual status %0d",
                         $time, status);
                errors++;
                return;
            end
            e = pending.pop_front();
            status_seen[e.status]++;
            compare_field("status", 16'(e.status), 16'(status));
            compare_field("owner_proc", e.oproc, oproc);
            compare_field("owner_thread", e.othread, othread);
        endfunction
    endclass

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    logic [1:0]      s_func = FUNC_LOOKUP;
    logic [10:0]     s_port = '0;
    logic [ID_W-1:0] s_caller_proc = '0;
    logic [ID_W-1:0] s_caller_thread = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    logic [2:0]      m_status;
    logic [ID_W-1:0] m_owner_proc;
    logic [ID_W-1:0] m_owner_thread;

    port_table_model model = new();

    int              send_idle = 0;
    int              recv_idle = 0;
    bit              hold_trigger = 1'b0;
    int              hold_left = 0;
    int              quiet_cycles = 0;
    logic [10:0]     hot_port[HOT_PORTS];
    logic [ID_W-1:0] pool_proc[CALLERS];
    logic [ID_W-1:0] pool_thread[CALLERS];

    port_owner_table dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_port          (s_port),
        .s_caller_proc   (s_caller_proc),
        .s_caller_thread (s_caller_thread),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_owner_proc    (m_owner_proc),
        .m_owner_thread  (m_owner_thread)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Result side: random back-pressure, with a long hold-off when hold_trigger is set.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_trigger) begin
                hold_left = LONG_HOLD;
                hold_trigger = 1'b0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            model.check_reply(m_status, m_owner_proc, m_owner_thread);
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles, %0d replies outstanding",
                     $time, QUIET_LIMIT, model.pending.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Valid is left high after acceptance; the next call either idles or presents
    // the next transaction at the following falling edge.
    task automatic send_request(logic [1:0] func, logic [10:0] port,
                                logic [ID_W-1:0] cproc, logic [ID_W-1:0] cthread);
        while ($urandom_range(99) < send_idle) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_func <= func;
        s_port <= port;
        s_caller_proc <= cproc;
        s_caller_thread <= cthread;
        do @(posedge aclk); while (!s_ready);
        model.apply_request(func, port, cproc, cthread);
    endtask

    task automatic wait_for_replies();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (model.pending.size() != 0)
            @(posedge aclk);
    endtask

    // Mostly a few hot ports and a small set of callers, so that claims, releases
    // and lookups keep colliding; the rest spans the whole field ranges.
    task automatic random_request();
        int              sel;
        int              k;
        logic [1:0]      func;
        logic [10:0]     port;
        logic [ID_W-1:0] cproc;
        logic [ID_W-1:0] cthread;
        sel = $urandom_range(99);
        if (sel < 35)
            func = FUNC_REGISTER;
        else if (sel < 60)
            func = FUNC_UNREGISTER;
        else if (sel < 97)
            func = FUNC_LOOKUP;
        else
            func = FUNC_UNREG_ALL;
        sel = $urandom_range(99);
        if (sel < 80)
            port = hot_port[$urandom_range(HOT_PORTS-1)];
        else if (sel < 90)
            port = 11'($urandom_range(PORTS-1));
        else
            port = 11'($urandom_range(2047));
        if ($urandom_range(9) == 0) begin
            cproc = 16'($urandom);
            cthread = 16'($urandom);
        end else begin
            k = $urandom_range(CALLERS-1);
            cproc = pool_proc[k];
            cthread = pool_thread[k];
        end
        send_request(func, port, cproc, cthread);
    endtask

    task automatic random_phase(int count);
        repeat (count) random_request();
        wait_for_replies();
    endtask

    initial begin
        hot_port[0] = '0;
        hot_port[1] = 11'(PORTS - 1);
        for (int i = 2; i < HOT_PORTS; i++)
            hot_port[i] = 11'($urandom_range(PORTS-1));
        // Pairs of callers share a process so that cross-thread release happens.
        for (int i = 0; i < CALLERS; i++) begin
            pool_proc[i] = (i % 2 == 0) ? 16'($urandom) : pool_proc[i-1];
            pool_thread[i] = 16'($urandom);
        end

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle = 16;
        recv_idle = 68;
        send_request(FUNC_LOOKUP, 11'(0), 16'h0000, 16'h0000);
        send_request(FUNC_UNREGISTER, 11'(0), 16'h0000, 16'h0000);
        send_request(FUNC_REGISTER, 11'(0), 16'h0000, 16'h0000);
        send_request(FUNC_REGISTER, 11'(0), 16'h1234, 16'h0001);
        send_request(FUNC_LOOKUP, 11'(0), 16'hFFFF, 16'hFFFF);
        send_request(FUNC_REGISTER, 11'(PORTS-1), 16'hFFFF, 16'hFFFF);
        send_request(FUNC_LOOKUP, 11'(PORTS-1), 16'h0000, 16'h0000);
        send_request(FUNC_REGISTER, 11'(PORTS), 16'h0001, 16'h0001);
        send_request(FUNC_UNREGISTER, 11'(2047), 16'hFFFF, 16'hFFFF);
        send_request(FUNC_LOOKUP, 11'(PORTS), 16'h0000, 16'h0000);
        send_request(FUNC_UNREGISTER, 11'(PORTS-1), 16'h1234, 16'hFFFF);
        send_request(FUNC_UNREGISTER, 11'(PORTS-1), 16'hFFFF, 16'h0000);
        send_request(FUNC_LOOKUP, 11'(PORTS-1), 16'h0000, 16'h0000);
        send_request(FUNC_REGISTER, 11'(5), 16'h0007, 16'h0001);
        send_request(FUNC_REGISTER, 11'(6), 16'h0007, 16'h0001);
        send_request(FUNC_REGISTER, 11'(7), 16'h0007, 16'h0002);
        send_request(FUNC_UNREG_ALL, 11'(2047), 16'h0007, 16'h0001);
        send_request(FUNC_LOOKUP, 11'(5), 16'h0000, 16'h0000);
        send_request(FUNC_LOOKUP, 11'(7), 16'h0000, 16'h0000);
        send_request(FUNC_UNREG_ALL, 11'(0), 16'h5555, 16'hAAAA);
        send_request(FUNC_UNREG_ALL, 11'(0), 16'h0000, 16'h0000);
        send_request(FUNC_LOOKUP, 11'(0), 16'h0000, 16'h0000);
        wait_for_replies();

        random_phase(430);

        send_idle = 68;
        recv_idle = 16;
        random_phase(430);

        // Free-running sender against a long receiver hold-off fills the block.
        send_idle = 0;
        recv_idle = 0;
        hold_trigger = 1'b1;
        random_phase(440);

        repeat (20) @(posedge aclk);
        $display("Run covered %0d register, %0d unregister, %0d lookup, %0d unregister-all",
                 model.func_seen[FUNC_REGISTER], model.func_seen[FUNC_UNREGISTER],
                 model.func_seen[FUNC_LOOKUP], model.func_seen[FUNC_UNREG_ALL]);
        $display("Replies: ok %0d, bad port %0d, taken %0d, unowned %0d, wrong process %0d",
                 model.status_seen[STATUS_OK], model.status_seen[STATUS_BAD_PORT],
                 model.status_seen[STATUS_ALREADY], model.status_seen[STATUS_NOT_REG],
                 model.status_seen[STATUS_NOT_OWNER]);
        if (model.errors == 0 && model.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ port_owner_table.f @@
design/pot_pkg.sv
design/pot_ram.sv
design/pot_front.sv
design/pot_back.sv
design/port_owner_table.sv
verif/tb_port_owner_table.sv
